// File: hw/rtl/pidr_pkg.sv
// Shared types, codes and saturating helpers for the PID regulator.
package pidr_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned OPND_W = 33;
	localparam int unsigned PROD_W = 2 * OPND_W;
	localparam int unsigned WIDE_W = 68;
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_ILIM  = 3'd3,
		REG_OLIM  = 3'd4,
		REG_RATE  = 3'd5,
		REG_DT    = 3'd6,
		REG_SPARE = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_UPDATE_DIFF   = 2'd0,
		KIND_UPDATE_STORED = 2'd1,
		KIND_LOAD          = 2'd2,
		KIND_CLEAR         = 2'd3
	} kind_t;

	// datapath step codes, one per controller phase
	typedef enum logic [2:0] {
		STEP_NONE   = 3'd0,
		STEP_P      = 3'd1,
		STEP_RATE   = 3'd2,
		STEP_DT     = 3'd3,
		STEP_KD     = 3'd4,
		STEP_KI     = 3'd5,
		STEP_TERM_I = 3'd6,
		STEP_SUM    = 3'd7
	} step_t;

	typedef struct packed {
		logic  err_from_in;
		logic  err_from_val;
		logic  clear;
		step_t step;
	} cmd_t;

	// saturate a wide signed value to the wb-bit signed range
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v,
			input int unsigned wb);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = (WIDE_W'(1) <<< (wb - 1)) - WIDE_W'(1);
		lo = -hi - WIDE_W'(1);
		if (v > hi) begin
			return hi[WORD_W-1:0];
		end else if (v < lo) begin
			return lo[WORD_W-1:0];
		end
		return v[WORD_W-1:0];
	endfunction

	// clamp to +-lim, lim of zero passes the value through
	function automatic logic signed [WORD_W-1:0] clamp_mag(input logic signed [WORD_W-1:0] v,
			input logic [WORD_W-2:0] lim);
		logic signed [WORD_W:0] vx;
		logic signed [WORD_W:0] lx;
		logic signed [WORD_W:0] nl;
		vx = (WORD_W+1)'(v);
		lx = signed'({2'b00, lim});
		nl = -lx;
		if (lim == '0) begin
			return v;
		end else if (vx > lx) begin
			return lx[WORD_W-1:0];
		end else if (vx < nl) begin
			return nl[WORD_W-1:0];
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/pid_regulator_clamped.sv
// PID regulator top level: controller plus datapath.
//
// Signed Q16.16 PID regulator with integral and output clamps. An update
// word (kind 0 or 1) goes from its accept cycle through the single shared 33x33
// multiplier (kp, loop rate, step time, kd, ki products and their write-back),
// and then to a final step that sums and clamps into the output register. Load
// and clear words finish in the accept cycle and give no drive word. A new word is
// accepted while a drive word still waits in the output register; the next
// update stalls only at its final sum until that register is taken.
// Configuration is written through the plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce;
// unused register indexes are ignored.
module pid_regulator_clamped import pidr_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [REG_IDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic signed [WORD_W-1:0] measured,
	input  logic signed [WORD_W-1:0] target,
	input  logic signed [WORD_W-1:0] error_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] drive
);

	cmd_t cmd;

	pidr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pidr_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.measured    (measured),
		.target      (target),
		.error_value (error_value),
		.cmd         (cmd),
		.drive       (drive)
	);

endmodule

// File: hw/rtl/pidr_ctrl.sv
// Sequencer for the PID regulator: handshakes and multiplier step order.
module pidr_ctrl import pidr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_P  = 8'b0000_0010,
		ST_MUL_R  = 8'b0000_0100,
		ST_MUL_DT = 8'b0000_1000,
		ST_MUL_KD = 8'b0001_0000,
		ST_MUL_KI = 8'b0010_0000,
		ST_TERM_I = 8'b0100_0000,
		ST_SUM    = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   take;
	logic   sum_fire;
	kind_t  kind_c;

	assign kind_c   = kind_t'(kind);
	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	// final sum waits until the output register is free
	assign sum_fire = (state_q == ST_SUM) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt        = state_q;
		cmd.err_from_in  = 1'b0;
		cmd.err_from_val = 1'b0;
		cmd.clear        = 1'b0;
		cmd.step         = STEP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (kind_c)
						KIND_UPDATE_DIFF: begin
							cmd.err_from_in = 1'b1;
							state_nxt       = ST_MUL_P;
						end
						KIND_UPDATE_STORED: state_nxt = ST_MUL_P;
						KIND_LOAD: cmd.err_from_val = 1'b1;
						KIND_CLEAR: cmd.clear = 1'b1;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_MUL_P: begin
				cmd.step  = STEP_P;
				state_nxt = ST_MUL_R;
			end
			ST_MUL_R: begin
				cmd.step  = STEP_RATE;
				state_nxt = ST_MUL_DT;
			end
			ST_MUL_DT: begin
				cmd.step  = STEP_DT;
				state_nxt = ST_MUL_KD;
			end
			ST_MUL_KD: begin
				cmd.step  = STEP_KD;
				state_nxt = ST_MUL_KI;
			end
			ST_MUL_KI: begin
				cmd.step  = STEP_KI;
				state_nxt = ST_TERM_I;
			end
			ST_TERM_I: begin
				cmd.step  = STEP_TERM_I;
				state_nxt = ST_SUM;
			end
			ST_SUM: begin
				if (sum_fire) begin
					cmd.step  = STEP_SUM;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (sum_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/pidr_datapath.sv
// PID regulator datapath: registers, state, shared multiplier and term logic.
module pidr_datapath import pidr_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [REG_IDX_W-1:0]        cfg_index,
	input  logic [WORD_W-1:0]           cfg_data,
	input  logic signed [WORD_W-1:0]    measured,
	input  logic signed [WORD_W-1:0]    target,
	input  logic signed [WORD_W-1:0]    error_value,
	input  cmd_t                        cmd,
	output logic signed [WORD_W-1:0]    drive
);

	localparam int unsigned WB = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

	// configuration
	logic signed [WORD_W-1:0] kp_q, ki_q, kd_q;
	logic [WORD_W-2:0]        ilim_q, olim_q;
	logic [15:0]              rate_q;
	logic [WORD_W-1:0]        dt_q;

	// loop state
	logic signed [WORD_W-1:0] err_q, prev_q, integ_q;

	// working registers
	logic signed [WORD_W-1:0] diff_q, deriv_q, p_q, d_q, i_q, drive_q;
	logic signed [OPND_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [WIDE_W-1:0] gain_term;
	logic signed [WIDE_W-1:0] integ_sum;
	logic signed [WIDE_W-1:0] term_sum;
	logic signed [WORD_W-1:0] integ_nxt;
	logic signed [WORD_W-1:0] drive_nxt;

	assign drive = drive_q;

	// Q16.16 times Q16.16 back to Q16.16, floor rounding via arithmetic shift
	assign gain_term = WIDE_W'(prod_q >>> 16);
	assign integ_sum = WIDE_W'(integ_q) + WIDE_W'(prod_q >>> 32);
	assign integ_nxt = clamp_mag(sat_word(integ_sum, WB), ilim_q);
	assign term_sum  = WIDE_W'(p_q) + WIDE_W'(d_q) + WIDE_W'(i_q);
	assign drive_nxt = clamp_mag(sat_word(term_sum, WB), olim_q);

	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.step)
			STEP_P: begin
				opa = OPND_W'(kp_q);
				opb = OPND_W'(err_q);
			end
			STEP_RATE: begin
				opa = OPND_W'(diff_q);
				opb = signed'({{(OPND_W-16){1'b0}}, rate_q});
			end
			STEP_DT: begin
				opa = OPND_W'(err_q);
				opb = signed'({1'b0, dt_q});
			end
			STEP_KD: begin
				opa = OPND_W'(kd_q);
				opb = OPND_W'(deriv_q);
			end
			// integral is already updated in the step before the ki product
			STEP_KI: begin
				opa = OPND_W'(ki_q);
				opb = OPND_W'(integ_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		case (cmd.step)
			STEP_P: diff_q <= sat_word(WIDE_W'(err_q) - WIDE_W'(prev_q), WB);
			STEP_RATE: p_q <= sat_word(gain_term, WB);
			STEP_DT: deriv_q <= sat_word(WIDE_W'(prod_q), WB);
			STEP_KI: d_q <= sat_word(gain_term, WB);
			STEP_TERM_I: i_q <= sat_word(gain_term, WB);
			STEP_SUM: drive_q <= drive_nxt;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			ilim_q  <= '0;
			olim_q  <= '0;
			rate_q  <= 16'd1000;
			dt_q    <= 32'd4294967;
			err_q   <= '0;
			prev_q  <= '0;
			integ_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (reg_idx_t'(cfg_index))
					REG_KP:   kp_q   <= signed'(cfg_data);
					REG_KI:   ki_q   <= signed'(cfg_data);
					REG_KD:   kd_q   <= signed'(cfg_data);
					REG_ILIM: ilim_q <= cfg_data[WORD_W-2:0];
					REG_OLIM: olim_q <= cfg_data[WORD_W-2:0];
					REG_RATE: rate_q <= cfg_data[15:0];
					REG_DT:   dt_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				err_q   <= '0;
				prev_q  <= '0;
				integ_q <= '0;
			end else if (cmd.err_from_in) begin
				err_q <= sat_word(WIDE_W'(target) - WIDE_W'(measured), WB);
			end else if (cmd.err_from_val) begin
				err_q <= sat_word(WIDE_W'(error_value), WB);
			end
			if (cmd.step == STEP_KD) begin
				integ_q <= integ_nxt;
			end
			if (cmd.step == STEP_SUM) begin
				prev_q <= err_q;
			end
		end
	end

endmodule

// File: test/pid_regulator_clamped_test.sv
// Self-checking testbench for the clamped PID regulator with a fixed-point predictor.
module pid_regulator_clamped_test import pidr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] Q_ONE = 32'h0001_0000;
	localparam longint WORD_HI = 64'sd2147483647;
	localparam longint WORD_LO = -64'sd2147483648;
	localparam int RANDOM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 155;
	localparam int SETTLE_CYCLES = 12;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct {
		kind_t             kind;
		logic signed [31:0] measured;
		logic signed [31:0] target;
		logic signed [31:0] error_value;
	} pid_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_KP;
	logic [WORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = KIND_UPDATE_DIFF;
	logic signed [WORD_W-1:0] measured = '0;
	logic signed [WORD_W-1:0] target = '0;
	logic signed [WORD_W-1:0] error_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [WORD_W-1:0] drive;

	pid_regulator_clamped i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.measured(measured),
		.target(target),
		.error_value(error_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive)
	);

	// predictor state and register shadow
	longint err_now = 0, err_last = 0, integ = 0;
	longint kp_now = 0, ki_now = 0, kd_now = 0;
	longint ilim_now = 0, olim_now = 0;
	longint rate_now = 1000, dt_now = 4294967;

	pid_word_t pending_words[$];
	logic signed [WORD_W-1:0] expected_drive[$];

	bit word_taken = 1'b0;
	bit calm = 1'b0;
	int src_idle_pct = 0, sink_stall_pct = 0;
	int src_hold = 0, sink_hold = 0;
	int words_in = 0, drives_checked = 0, settings_done = 0, fails = 0;
	int cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint sat_q(longint v);
		if (v > WORD_HI) return WORD_HI;
		if (v < WORD_LO) return WORD_LO;
		return v;
	endfunction

	function automatic longint clamp_q(longint v, longint lim);
		if (lim == 0) return v;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// advances the regulator state for one accepted word, queues its drive word if any
	function automatic void regulate(kind_t k, logic signed [31:0] m, logic signed [31:0] t,
			logic signed [31:0] ev);
		longint mv, tv, p, diff, deriv, d, inc, i_term, sum;
		mv = m;
		tv = t;
		case (k)
			KIND_LOAD: begin
				err_now = ev;
			end
			KIND_CLEAR: begin
				err_now = 0;
				err_last = 0;
				integ = 0;
			end
			default: begin
				if (k == KIND_UPDATE_DIFF) err_now = sat_q(tv - mv);
				p = sat_q((kp_now * err_now) >>> 16);
				diff = sat_q(err_now - err_last);
				deriv = sat_q(diff * rate_now);
				d = sat_q((kd_now * deriv) >>> 16);
				inc = (err_now * dt_now) >>> 32;
				integ = clamp_q(sat_q(integ + inc), ilim_now);
				i_term = sat_q((ki_now * integ) >>> 16);
				err_last = err_now;
				sum = clamp_q(sat_q(p + d + i_term), olim_now);
				expected_drive.push_back(32'(sum));
			end
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KP:   kp_now = $signed(val);
			REG_KI:   ki_now = $signed(val);
			REG_KD:   kd_now = $signed(val);
			REG_ILIM: ilim_now = val[30:0];
			REG_OLIM: olim_now = val[30:0];
			REG_RATE: rate_now = val[15:0];
			REG_DT:   dt_now = val;
			default:  ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_setting(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
			logic [31:0] ilim, logic [31:0] olim, logic [31:0] rate, logic [31:0] dt);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_ILIM, ilim);
		write_reg(REG_OLIM, olim);
		write_reg(REG_RATE, rate);
		write_reg(REG_DT, dt);
		settings_done++;
	endtask

	function automatic void queue_word(kind_t k, logic [31:0] m, logic [31:0] t,
			logic [31:0] ev);
		pending_words.push_back('{k, m, t, ev});
	endfunction

	function automatic logic [31:0] signed_small(int unsigned mag);
		logic [31:0] v;
		v = $urandom_range(mag);
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(5))
			0, 1:    return $urandom();
			2, 3, 4: return signed_small(32'h0004_0000);
			default: return '0;
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(3))
			0:       return '0;
			1:       return $urandom();
			default: return $urandom_range(32'h0010_0000, 1);
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return signed_small(32'h0008_0000);
			4, 5, 6, 7: return $urandom();
			8: begin
				case ($urandom_range(4))
					0:       return Q_MIN;
					1:       return Q_MAX;
					2:       return '0;
					3:       return '1;
					default: return 32'd1;
				endcase
			end
			default: return $urandom_range(1) ? Q_MAX - $urandom_range(255)
				: Q_MIN + $urandom_range(255);
		endcase
	endfunction

	task automatic random_setting();
		logic [31:0] rate, dt;
		case ($urandom_range(3))
			0:       rate = $urandom();
			1:       rate = '0;
			default: rate = $urandom_range(2000, 1);
		endcase
		if (rate[15:0] != 0 && $urandom_range(1))
			dt = 32'(64'h1_0000_0000 / rate[15:0]);
		else
			dt = $urandom();
		write_setting(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(), rate, dt);
	endtask

	// wait until every queued word went in and every drive word came back
	task automatic drain();
		@(posedge clk);
		while (pending_words.size() != 0 || in_valid || expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// source side: next word or an idle burst, changed on the falling edge
	always @(negedge clk) begin
		pid_word_t w;
		bit send;
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 1'b0;
			send = 1'b0;
			if (src_hold > 0) begin
				src_hold--;
			end else if (pending_words.size() != 0) begin
				if (!calm && $urandom_range(99) < src_idle_pct) begin
					src_hold = $urandom_range(4);
				end else begin
					w = pending_words.pop_front();
					send = 1'b1;
					kind <= w.kind;
					measured <= w.measured;
					target <= w.target;
					error_value <= w.error_value;
				end
			end
			in_valid <= send;
		end
	end

	// sink side stalls
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_ready <= !calm ? 1'b0 : 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold--;
			out_ready <= 1'b0;
		end else if ($urandom_range(99) < sink_stall_pct) begin
			sink_hold = $urandom_range(4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic signed [WORD_W-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				word_taken = 1'b1;
				words_in++;
				regulate(kind_t'(kind), measured, target, error_value);
			end
			if (out_valid && out_ready) begin
				drives_checked++;
				if (expected_drive.size() == 0) begin
					fails++;
					if (fails <= 20)
						$display("%0t: extra drive: expected none, got %0d (0x%08h)",
							$time, drive, drive);
				end else begin
					want = expected_drive.pop_front();
					if (drive !== want) begin
						fails++;
						if (fails <= 20)
							$display("%0t: drive: expected %0d (0x%08h), got %0d (0x%08h)",
								$time, want, want, drive, drive);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d drive words still expected", $time,
				expected_drive.size());
			$display("pid_regulator_clamped_test: FAIL");
			$finish;
		end
	end

	initial begin
		kind_t k;
		int pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gains: drive stays zero, but state still moves
		queue_word(KIND_UPDATE_DIFF, Q_MAX, Q_MIN, '0);
		queue_word(KIND_UPDATE_DIFF, Q_MIN, Q_MAX, '0);
		queue_word(KIND_LOAD, '0, '0, Q_MAX);
		queue_word(KIND_UPDATE_STORED, '1, '1, '1);
		queue_word(KIND_CLEAR, Q_MAX, Q_MAX, Q_MAX);
		queue_word(KIND_UPDATE_STORED, '0, '0, '0);
		drain();

		// extreme gains, full-scale rate and step, limit written with bit 31 set
		write_setting(Q_MAX, Q_MIN, Q_ONE, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(KIND_LOAD, '0, '0, Q_MIN);
		queue_word(KIND_UPDATE_STORED, '0, '0, '0);
		queue_word(KIND_UPDATE_DIFF, '0, '0, '0);
		queue_word(KIND_UPDATE_DIFF, 32'd1, '0, '0);
		queue_word(KIND_UPDATE_DIFF, Q_MAX, Q_MAX, '0);
		queue_word(KIND_UPDATE_DIFF, Q_MIN, '0, '0);
		queue_word(KIND_CLEAR, '0, '0, '0);
		drain();

		// zero rate and zero step: no derivative, frozen integral; tight clamps
		write_setting(32'hFFFF_0000, Q_ONE, Q_MIN, 32'h0002_0000, 32'h0000_8000, '0, '0);
		write_reg(REG_SPARE, '1);
		queue_word(KIND_UPDATE_DIFF, 32'h0003_0000, '0, '0);
		queue_word(KIND_UPDATE_DIFF, '0, 32'h0003_0000, '0);
		queue_word(KIND_LOAD, '0, '0, 32'hFFFF_FFF0);
		queue_word(KIND_UPDATE_STORED, '0, '0, '0);
		drain();

		// nominal loop
		write_setting(32'h0002_0000, 32'h0000_8000, 32'h0000_0200, 32'h0004_0000,
			32'h0010_0000, 32'd1000, 32'd4294967);
		queue_word(KIND_UPDATE_DIFF, '0, 32'h0001_8000, '0);
		queue_word(KIND_UPDATE_DIFF, 32'h0000_4000, 32'h0001_8000, '0);
		queue_word(KIND_UPDATE_STORED, '0, '0, '0);
		queue_word(KIND_UPDATE_DIFF, 32'h0002_0000, '0, '0);
		queue_word(KIND_CLEAR, '0, '0, '0);
		queue_word(KIND_UPDATE_DIFF, 32'h0001_0000, 32'h0001_0000, '0);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_setting();
			calm = (ph == RANDOM_PHASES - 1);
			src_idle_pct = (ph % 3 == 1) ? 0 : $urandom_range(40, 5);
			sink_stall_pct = (ph % 3 == 2) ? 0 : $urandom_range(40, 5);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 45) k = KIND_UPDATE_DIFF;
				else if (pick < 75) k = KIND_UPDATE_STORED;
				else if (pick < 92) k = KIND_LOAD;
				else k = KIND_CLEAR;
				queue_word(k, pick_value(), pick_value(), pick_value());
			end
			drain();
		end

		$display("Ran %0d words through %0d register settings; %0d drive words checked.",
			words_in, settings_done, drives_checked);
		$display("Covered all word kinds, clamps on and off, zero rate and step, stalls.");
		if (fails == 0) begin
			$display("pid_regulator_clamped_test: PASS");
		end else begin
			$display("%0d mismatches", fails);
			$display("pid_regulator_clamped_test: FAIL");
		end
		$finish;
	end

endmodule
